// ===== sv/sfa_pkg.sv =====
// Shared types and codes for the sprite frame animator.
// No dependencies; used by every design module of the block.
package sfa_pkg;

  localparam int MODE_COUNT = 5;
  localparam int MODE_BITS  = 3;

  typedef enum logic [MODE_BITS-1:0] {
    MODE_IDLE    = 3'd0,
    MODE_WALKING = 3'd1,
    MODE_JUMPING = 3'd2,
    MODE_BRAKING = 3'd3,
    MODE_DEAD    = 3'd4
  } mode_e;

  typedef enum logic {
    CMD_SET_MODE = 1'b0,
    CMD_TICK     = 1'b1
  } cmd_e;

  // One frame range register: last frame in the upper byte.
  typedef struct packed {
    logic [7:0] last;
    logic [7:0] first;
  } range_t;

  // Frame stage result handed to the position stage.
  typedef struct packed {
    logic [7:0] frame;
    logic [7:0] quot;
    logic       changed;
  } frame_t;

endpackage

// ===== sv/sprite_frame_animator.sv =====
// Sprite frame animator: one item per clock, mode set or time tick, one result
// per item, offered once it has passed through the input, frame and result
// registers. The range registers are read live and written through
// cfg_we_i/cfg_idx_i/cfg_data_i (index 0 idle to 4 dead); write them while no
// item is in flight. Throughput is one item per cycle; s_axis_tready drops only
// when all three stages hold items and m_axis_tready is low. Depends on sfa_pkg
// and the sfa_ modules.
module sprite_frame_animator #(
  parameter int TICKS_PER_STEP   = 8,
  parameter int TILES_PER_ROW    = 8,
  parameter int TILE_WIDTH       = 32,
  parameter int TILE_HEIGHT      = 32,
  parameter int FRAME_INDEX_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,  // [2:0] new_mode
  input  logic                          s_axis_tuser,  // [0] cmd
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] frame_index, [15:8] sheet_x, [25:16] sheet_y, [26] frame_changed
  output logic [31:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [sfa_pkg::MODE_BITS-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_data_i
);

  sfa_pkg::range_t               ranges [sfa_pkg::MODE_COUNT];
  logic                          a_valid_q;
  logic                          a_cmd_q;
  logic [sfa_pkg::MODE_BITS-1:0] a_mode_q;
  logic                          ready_b;
  logic                          ready_c;
  logic                          b_valid;
  sfa_pkg::frame_t               b_data;

  assign s_axis_tready = !a_valid_q || ready_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      a_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      a_cmd_q  <= s_axis_tuser;
      a_mode_q <= s_axis_tdata[sfa_pkg::MODE_BITS-1:0];
    end
  end

  sfa_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .ranges_o (ranges)
  );

  sfa_anim_core #(
    .TICKS_PER_STEP   (TICKS_PER_STEP),
    .TILES_PER_ROW    (TILES_PER_ROW),
    .FRAME_INDEX_BITS (FRAME_INDEX_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .a_valid_i (a_valid_q),
    .a_cmd_i   (a_cmd_q),
    .a_mode_i  (a_mode_q),
    .ranges_i  (ranges),
    .ready_c_i (ready_c),
    .ready_b_o (ready_b),
    .b_valid_o (b_valid),
    .b_data_o  (b_data)
  );

  sfa_sheet_pos #(
    .TILES_PER_ROW (TILES_PER_ROW),
    .TILE_WIDTH    (TILE_WIDTH),
    .TILE_HEIGHT   (TILE_HEIGHT)
  ) u_pos (
    .clk_i,
    .rst_ni,
    .b_valid_i (b_valid),
    .b_data_i  (b_data),
    .ready_c_o (ready_c),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

// ===== sv/sfa_cfg_regs.sv =====
// Frame range registers, one per animation mode, behind a plain write port.
// Depends on sfa_pkg.
module sfa_cfg_regs (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [sfa_pkg::MODE_BITS-1:0]         cfg_idx_i,
  input  logic [15:0]                           cfg_data_i,
  output sfa_pkg::range_t                       ranges_o [sfa_pkg::MODE_COUNT]
);

  sfa_pkg::range_t ranges_q [sfa_pkg::MODE_COUNT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sfa_pkg::MODE_COUNT; i++) begin
        ranges_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < sfa_pkg::MODE_BITS'(sfa_pkg::MODE_COUNT))) begin
      ranges_q[cfg_idx_i] <= sfa_pkg::range_t'(cfg_data_i);
    end
  end

  assign ranges_o = ranges_q;

endmodule

// ===== sv/sfa_anim_core.sv =====
// Animation state (mode, tick timer, frame offset, shown frame) and the frame
// register stage. Depends on sfa_pkg.
module sfa_anim_core #(
  parameter int TICKS_PER_STEP   = 8,
  parameter int TILES_PER_ROW    = 8,
  parameter int FRAME_INDEX_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          a_valid_i,
  input  logic                          a_cmd_i,
  input  logic [sfa_pkg::MODE_BITS-1:0] a_mode_i,
  input  sfa_pkg::range_t               ranges_i [sfa_pkg::MODE_COUNT],
  input  logic                          ready_c_i,
  output logic                          ready_b_o,
  output logic                          b_valid_o,
  output sfa_pkg::frame_t               b_data_o
);

  localparam int TickBits = (TICKS_PER_STEP > 1) ? $clog2(TICKS_PER_STEP) : 1;
  localparam logic [TickBits-1:0] TickLast = TickBits'(TICKS_PER_STEP - 1);
  localparam int FrameBits = (FRAME_INDEX_BITS < 8) ? FRAME_INDEX_BITS : 8;
  localparam logic [7:0] FrameMask = 8'((1 << FrameBits) - 1);
  // Reciprocal for the row number; exact for 8-bit frames.
  localparam int RecipVal = (65536 + TILES_PER_ROW - 1) / TILES_PER_ROW;
  localparam logic [16:0] Recip = 17'(RecipVal);

  sfa_pkg::mode_e        mode_q, mode_d;
  logic [TickBits-1:0]   tick_q, tick_d;
  logic [7:0]            offset_q, offset_d;
  logic [7:0]            shown_q;
  logic                  b_valid_q;
  sfa_pkg::frame_t       b_data_q;

  sfa_pkg::range_t       sel;
  logic [8:0]            range_len;
  logic [8:0]            next_off;
  logic [8:0]            sum;
  logic [7:0]            frame;
  logic [24:0]           quot_prod;
  logic                  advance;

  assign ready_b_o = !b_valid_q || ready_c_i;
  assign advance   = a_valid_i && ready_b_o;

  always_comb begin
    mode_d   = mode_q;
    tick_d   = tick_q;
    offset_d = offset_q;
    next_off = {1'b0, offset_q} + 9'd1;
    if (a_cmd_i == sfa_pkg::CMD_SET_MODE) begin
      if ((a_mode_i < sfa_pkg::MODE_BITS'(sfa_pkg::MODE_COUNT)) && (a_mode_i != mode_q)) begin
        mode_d   = sfa_pkg::mode_e'(a_mode_i);
        offset_d = '0;
        tick_d   = '0;
      end
    end
    // A tick keeps the mode, so the range of the new mode serves both paths.
    sel       = ranges_i[mode_d];
    range_len = (sel.last >= sel.first) ? ({1'b0, sel.last} - {1'b0, sel.first} + 9'd1)
                                        : 9'd1;
    if (a_cmd_i == sfa_pkg::CMD_TICK) begin
      if (tick_q == TickLast) begin
        tick_d   = '0;
        offset_d = (next_off >= range_len) ? 8'd0 : next_off[7:0];
      end else begin
        tick_d = tick_q + TickBits'(1);
      end
    end
    sum       = {1'b0, sel.first} + {1'b0, offset_d};
    frame     = sum[7:0] & FrameMask;
    quot_prod = 25'(frame) * 25'(Recip);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= sfa_pkg::MODE_IDLE;
      tick_q    <= '0;
      offset_q  <= '0;
      shown_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      if (ready_b_o) begin
        b_valid_q <= a_valid_i;
      end
      if (advance) begin
        mode_q   <= mode_d;
        tick_q   <= tick_d;
        offset_q <= offset_d;
        shown_q  <= frame;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      b_data_q.frame   <= frame;
      b_data_q.quot    <= quot_prod[23:16];
      b_data_q.changed <= (frame != shown_q);
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_data_o  = b_data_q;

endmodule

// ===== sv/sfa_sheet_pos.sv =====
// Sheet pixel position of a frame and the result register stage.
// Depends on sfa_pkg.
module sfa_sheet_pos #(
  parameter int TILES_PER_ROW = 8,
  parameter int TILE_WIDTH    = 32,
  parameter int TILE_HEIGHT   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            b_valid_i,
  input  sfa_pkg::frame_t b_data_i,
  output logic            ready_c_o,
  output logic            m_valid_o,
  input  logic            m_ready_i,
  output logic [31:0]     m_data_o
);

  logic        c_valid_q;
  logic [31:0] c_data_q;
  logic [15:0] row_base;
  logic [7:0]  col;
  logic [19:0] x_prod;
  logic [19:0] y_prod;

  assign ready_c_o = !c_valid_q || m_ready_i;

  always_comb begin
    row_base = 16'(b_data_i.quot) * 16'(TILES_PER_ROW);
    col      = b_data_i.frame - row_base[7:0];
    x_prod   = 20'(col) * 20'(TILE_WIDTH);
    y_prod   = 20'(b_data_i.quot) * 20'(TILE_HEIGHT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (ready_c_o) begin
      c_valid_q <= b_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_c_o && b_valid_i) begin
      c_data_q <= {5'd0, b_data_i.changed, y_prod[9:0], x_prod[7:0], b_data_i.frame};
    end
  end

  assign m_valid_o = c_valid_q;
  assign m_data_o  = c_data_q;

endmodule

// ===== sv/sfa_checker.sv =====
// Port-level checks for the sprite frame animator, bound to the top level.
// Depends only on the top level's ports.
module sfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  logic [2:0] pending_q;
  logic [7:0] last_frame_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // Count items taken but not yet delivered; track the last delivered frame.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q    <= '0;
      last_frame_q <= '0;
    end else begin
      pending_q <= pending_q + {2'd0, in_acc} - {2'd0, out_acc};
      if (out_acc) begin
        last_frame_q <= m_axis_tdata[7:0];
      end
    end
  end

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> pending_q != 3'd0)
    else $error("result with no item in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd3)
    else $error("more items in flight than pipeline stages");

  a_changed_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc |-> m_axis_tdata[26] == (m_axis_tdata[7:0] != last_frame_q))
    else $error("frame_changed disagrees with delivered frames");

endmodule

bind sprite_frame_animator sfa_checker u_sfa_checker (.*);
